>>> src/cursor_doubly_linked_list_macros.svh
// Assertion macros for the cursor list checker
`ifndef CURSOR_DOUBLY_LINKED_LIST_MACROS_SVH
`define CURSOR_DOUBLY_LINKED_LIST_MACROS_SVH
// implication checked every clock, off during reset
`define CDLL_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define CDLL_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

>>> src/cdll_pkg.sv
// Package: types, codes and sizes for the cursor linked list
package cdll_pkg;
   localparam int NodeCount = 16;
   localparam int DataWidth = 32;
   localparam int PtrWidth  = $clog2(NodeCount + 1);
   localparam int IdxWidth  = $clog2(NodeCount);
   localparam logic [PtrWidth-1:0] NullPtr = PtrWidth'(NodeCount);

   localparam logic [3:0] OpFirst = 4'd0;
   localparam logic [3:0] OpNext = 4'd1;
   localparam logic [3:0] OpLast = 4'd2;
   localparam logic [3:0] OpPrev = 4'd3;
   localparam logic [3:0] OpPushFront = 4'd4;
   localparam logic [3:0] OpPushBack = 4'd5;
   localparam logic [3:0] OpPushCursor = 4'd6;
   localparam logic [3:0] OpPopFront = 4'd7;
   localparam logic [3:0] OpPopBack = 4'd8;
   localparam logic [3:0] OpPopCursor = 4'd9;
   localparam logic [3:0] OpClear = 4'd10;

   localparam logic [1:0] StOk = 2'd0;
   localparam logic [1:0] StEmpty = 2'd1;
   localparam logic [1:0] StNullCursor = 2'd2;
   localparam logic [1:0] StFull = 2'd3;

   typedef struct packed {
      logic [3:0]  req_type;
      logic [31:0] data_in;
   } req_type_type;

   typedef struct packed {
      logic [31:0] data_out;
      logic        has_data;
      logic [1:0]  status;
   } rsp_type_type;

   // one node of the pool
   typedef struct packed {
      logic [DataWidth-1:0] value;
      logic [PtrWidth-1:0]  next;
      logic [PtrWidth-1:0]  prev;
   } node_type;

   // allocator result
   typedef struct packed {
      logic                found;
      logic [IdxWidth-1:0] idx;
   } alloc_type;
endpackage

>>> src/cursor_doubly_linked_list.sv
// Top level: cursor linked list sequencer over a node pool with one read and one write port
//  channel | ports                      | dir
//  request | req_valid req_stall req_data | in
//  result  | rsp_valid rsp_stall rsp_data | out
// Each request runs as a sequence of node reads through the pool's registered read
// port and node writes through its write port.
// Reset empties the list at once (head, tail, cursor null, all nodes free).
// req_stall stays high from acceptance until the result transfer.
module cursor_doubly_linked_list (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  cdll_pkg::req_type_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output cdll_pkg::rsp_type_type rsp_data
);
   localparam int PW = cdll_pkg::PtrWidth;
   localparam int IW = cdll_pkg::IdxWidth;

   typedef enum logic [3:0] {
      S_IDLE, S_DEC, S_RD, S_WAIT, S_USE, S_W1, S_W2, S_W3, S_RESP
   } state_type;

   // action being carried out after decode
   typedef enum logic [2:0] {
      A_MOVE, A_STEP, A_PUSHF, A_PUSHA, A_POP
   } act_type;

   state_type state_ff;
   act_type   act_ff;
   logic [3:0]           op_ff;
   logic [cdll_pkg::DataWidth-1:0] val_ff;
   logic [PW-1:0] head_ff, tail_ff, cur_ff, old_cur_ff;
   logic [PW-1:0] tgt_ff;           // node under work
   logic [IW-1:0] new_ff;           // allocated node
   cdll_pkg::node_type nd_ff;       // copy of node under work
   cdll_pkg::node_type nb_ff;       // neighbour read for rewrite
   logic [1:0] phase_ff;
   cdll_pkg::rsp_type_type rsp_ff;

   logic [IW-1:0] rd_idx, wr_idx;
   cdll_pkg::node_type rd_node, wr_node;
   logic wr_en;
   logic take, give, clr;
   cdll_pkg::alloc_type pick;

   // the popped node is held in old_cur_ff from its read onwards
   cdll_alloc u_alloc (
      .clock(clock), .reset(reset), .take(take), .give(give),
      .give_idx(old_cur_ff[IW-1:0]), .clear_all(clr), .pick(pick)
   );
   cdll_pool u_pool (
      .clock(clock), .rd_idx(rd_idx), .rd_node(rd_node),
      .wr_en(wr_en), .wr_idx(wr_idx), .wr_node(wr_node)
   );

   function automatic logic ok(input logic [PW-1:0] p);
      return p < cdll_pkg::NullPtr;
   endfunction

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_data  = rsp_ff;
   assign rd_idx    = tgt_ff[IW-1:0];

   // write port and allocator controls
   always_comb begin
      wr_en = 1'b0; wr_idx = '0; wr_node = nd_ff;
      take = 1'b0; give = 1'b0; clr = 1'b0;
      if (state_ff == S_DEC && op_ff == cdll_pkg::OpClear) clr = 1'b1;
      if (state_ff == S_W1) begin
         wr_en = 1'b1;
         if (act_ff == A_POP) begin
            // previous node: next <- popped.next
            wr_idx = nd_ff.prev[IW-1:0];
            wr_node = nb_ff; wr_node.next = nd_ff.next;
            wr_en = ok(nd_ff.prev);
            give = 1'b1;
         end else begin
            wr_idx = new_ff;
            wr_node.value = val_ff;
            if (act_ff == A_PUSHF) begin
               wr_node.next = head_ff; wr_node.prev = cdll_pkg::NullPtr;
            end else begin
               wr_node.next = nd_ff.next; wr_node.prev = tgt_ff;
            end
         end
      end
      if (state_ff == S_W2) begin
         if (act_ff == A_POP) begin
            wr_idx = nd_ff.next[IW-1:0];
            wr_node = nb_ff; wr_node.prev = nd_ff.prev;
            wr_en = ok(nd_ff.next);
         end else if (act_ff == A_PUSHF) begin
            // old head, still in tgt_ff: prev <- new
            wr_idx = tgt_ff[IW-1:0];
            wr_node = nb_ff; wr_node.prev = PW'(new_ff);
            wr_en = ok(tgt_ff);
         end else begin
            // cursor node: next <- new
            wr_idx = tgt_ff[IW-1:0];
            wr_node = nd_ff; wr_node.next = PW'(new_ff);
            wr_en = 1'b1;
         end
      end
      if (state_ff == S_W3) begin
         // push after: old next's prev <- new
         wr_idx = nd_ff.next[IW-1:0];
         wr_node = nb_ff; wr_node.prev = PW'(new_ff);
         wr_en = ok(nd_ff.next);
      end
      if (state_ff == S_DEC) begin
         take = ((op_ff == cdll_pkg::OpPushFront) ||
                 (op_ff == cdll_pkg::OpPushBack && !ok(tail_ff)) ||
                 (op_ff == cdll_pkg::OpPushBack && ok(tail_ff)) ||
                 (op_ff == cdll_pkg::OpPushCursor && ok(cur_ff)));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         head_ff <= cdll_pkg::NullPtr;
         tail_ff <= cdll_pkg::NullPtr;
         cur_ff <= cdll_pkg::NullPtr;
         act_ff <= A_MOVE;
         phase_ff <= '0;
      end else begin
         unique case (state_ff)
            S_IDLE: if (req_valid) begin
               op_ff <= req_data.req_type;
               val_ff <= req_data.data_in;
               old_cur_ff <= cur_ff;
               rsp_ff <= '{data_out: '0, has_data: 1'b0, status: cdll_pkg::StOk};
               state_ff <= S_DEC;
            end
            S_DEC: begin
               new_ff <= pick.idx;
               phase_ff <= '0;
               case (op_ff)
                  cdll_pkg::OpFirst, cdll_pkg::OpLast: begin
                     tgt_ff <= (op_ff == cdll_pkg::OpFirst) ? head_ff : tail_ff;
                     if (!ok((op_ff == cdll_pkg::OpFirst) ? head_ff : tail_ff)) begin
                        rsp_ff.status <= cdll_pkg::StEmpty; state_ff <= S_RESP;
                     end else begin act_ff <= A_MOVE; state_ff <= S_RD; end
                  end
                  cdll_pkg::OpNext, cdll_pkg::OpPrev: begin
                     tgt_ff <= cur_ff;
                     if (!ok(cur_ff)) begin
                        rsp_ff.status <= cdll_pkg::StNullCursor; state_ff <= S_RESP;
                     end else begin act_ff <= A_STEP; state_ff <= S_RD; end
                  end
                  cdll_pkg::OpPushFront, cdll_pkg::OpPushBack,
                  cdll_pkg::OpPushCursor: begin
                     if (op_ff == cdll_pkg::OpPushCursor && !ok(cur_ff)) begin
                        rsp_ff.status <= cdll_pkg::StNullCursor; state_ff <= S_RESP;
                     end else if (!pick.found) begin
                        rsp_ff.status <= cdll_pkg::StFull; state_ff <= S_RESP;
                     end else if (op_ff == cdll_pkg::OpPushFront || !ok(tail_ff)) begin
                        act_ff <= A_PUSHF; tgt_ff <= head_ff;
                        // neighbour is the old head
                        state_ff <= ok(head_ff) ? S_RD : S_W1;
                     end else begin
                        act_ff <= A_PUSHA;
                        tgt_ff <= (op_ff == cdll_pkg::OpPushBack) ? tail_ff : cur_ff;
                        if (op_ff == cdll_pkg::OpPushBack) cur_ff <= tail_ff;
                        state_ff <= S_RD;
                     end
                  end
                  cdll_pkg::OpPopFront, cdll_pkg::OpPopBack, cdll_pkg::OpPopCursor: begin
                     logic [PW-1:0] c;
                     c = (op_ff == cdll_pkg::OpPopFront) ? head_ff :
                         (op_ff == cdll_pkg::OpPopBack) ? tail_ff : cur_ff;
                     cur_ff <= c; tgt_ff <= c;
                     if (!ok(c)) begin
                        rsp_ff.status <= (op_ff == cdll_pkg::OpPopCursor) ?
                           cdll_pkg::StNullCursor : cdll_pkg::StEmpty;
                        state_ff <= S_RESP;
                     end else begin act_ff <= A_POP; state_ff <= S_RD; end
                  end
                  cdll_pkg::OpClear: begin
                     head_ff <= cdll_pkg::NullPtr; tail_ff <= cdll_pkg::NullPtr;
                     cur_ff <= cdll_pkg::NullPtr;
                     state_ff <= S_RESP;
                  end
                  default: state_ff <= S_RESP;
               endcase
            end
            S_RD: state_ff <= S_WAIT;   // read address presented
            S_WAIT: state_ff <= S_USE;  // read data registered
            S_USE: begin
               // phase 0: node under work (neighbour for push front); phases 1 and 2: neighbour
               if (phase_ff == 2'd0 && act_ff != A_PUSHF) nd_ff <= rd_node;
               else nb_ff <= rd_node;
               unique case (act_ff)
                  A_MOVE: begin
                     cur_ff <= tgt_ff;
                     rsp_ff <= '{data_out: rd_node.value, has_data: 1'b1,
                                 status: cdll_pkg::StOk};
                     state_ff <= S_RESP;
                  end
                  A_STEP: begin
                     if (phase_ff == 2'd0) begin
                        logic [PW-1:0] t;
                        t = (op_ff == cdll_pkg::OpNext) ? rd_node.next : rd_node.prev;
                        if (!ok(t)) begin
                           rsp_ff.status <= cdll_pkg::StEmpty; state_ff <= S_RESP;
                        end else begin
                           tgt_ff <= t; phase_ff <= 2'd1; state_ff <= S_RD;
                        end
                     end else begin
                        cur_ff <= tgt_ff;
                        rsp_ff <= '{data_out: rd_node.value, has_data: 1'b1,
                                    status: cdll_pkg::StOk};
                        state_ff <= S_RESP;
                     end
                  end
                  A_PUSHF: state_ff <= S_W1;
                  A_PUSHA: begin
                     if (phase_ff == 2'd0 && ok(rd_node.next)) begin
                        phase_ff <= 2'd1; tgt_ff <= rd_node.next;
                        old_cur_ff <= tgt_ff; state_ff <= S_RD;
                     end else begin
                        if (phase_ff != 2'd0) tgt_ff <= old_cur_ff;
                        state_ff <= S_W1;
                     end
                  end
                  A_POP: begin
                     if (phase_ff == 2'd0) begin
                        rsp_ff <= '{data_out: rd_node.value, has_data: 1'b1,
                                    status: cdll_pkg::StOk};
                        old_cur_ff <= tgt_ff;
                        if (ok(rd_node.prev)) begin
                           tgt_ff <= rd_node.prev; phase_ff <= 2'd1; state_ff <= S_RD;
                        end else state_ff <= S_W1;
                     end else if (phase_ff == 2'd1) begin
                        // nb holds prev; write it, then fetch next
                        state_ff <= S_W1;
                     end else begin
                        state_ff <= S_W2;
                     end
                  end
                  default: state_ff <= S_RESP;
               endcase
            end
            S_W1: begin
               if (act_ff == A_POP) begin
                  if (!ok(nd_ff.prev)) head_ff <= nd_ff.next;
                  if (ok(nd_ff.next)) begin
                     tgt_ff <= nd_ff.next; phase_ff <= 2'd2; state_ff <= S_RD;
                  end else begin
                     tail_ff <= nd_ff.prev; cur_ff <= cdll_pkg::NullPtr;
                     state_ff <= S_RESP;
                  end
               end else if (act_ff == A_PUSHF) begin
                  head_ff <= PW'(new_ff);
                  if (!ok(head_ff)) begin
                     tail_ff <= PW'(new_ff); state_ff <= S_RESP;
                  end else state_ff <= S_W2;
               end else state_ff <= S_W2;
            end
            S_W2: begin
               if (act_ff == A_POP) begin
                  cur_ff <= nd_ff.next; state_ff <= S_RESP;
               end else if (act_ff == A_PUSHA) begin
                  if (tail_ff == tgt_ff) tail_ff <= PW'(new_ff);
                  state_ff <= ok(nd_ff.next) ? S_W3 : S_RESP;
               end else state_ff <= S_RESP;
            end
            S_W3: state_ff <= S_RESP;
            S_RESP: if (!rsp_stall) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

>>> src/cdll_alloc.sv
// Free map: lowest-free-node search, allocate, release and clear
module cdll_alloc (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          take,
   input  logic                          give,
   input  logic [cdll_pkg::IdxWidth-1:0] give_idx,
   input  logic                          clear_all,
   output cdll_pkg::alloc_type           pick
);
   logic [cdll_pkg::NodeCount-1:0] free_ff, free_in;

   always_comb begin
      pick.found = 1'b0;
      pick.idx = '0;
      for (int i = cdll_pkg::NodeCount - 1; i >= 0; i--) begin
         if (free_ff[i]) begin
            pick.found = 1'b1;
            pick.idx = cdll_pkg::IdxWidth'(i);
         end
      end
      free_in = free_ff;
      if (take && pick.found) free_in[pick.idx] = 1'b0;
      if (give) free_in[give_idx] = 1'b1;
      if (clear_all) free_in = '1;
   end

   always_ff @(posedge clock) begin
      if (reset) free_ff <= '1;
      else free_ff <= free_in;
   end
endmodule

>>> src/cdll_pool.sv
// Node pool memory: one registered read port, one write port
module cdll_pool (
   input  logic                          clock,
   input  logic [cdll_pkg::IdxWidth-1:0] rd_idx,
   output cdll_pkg::node_type            rd_node,
   input  logic                          wr_en,
   input  logic [cdll_pkg::IdxWidth-1:0] wr_idx,
   input  cdll_pkg::node_type            wr_node
);
   cdll_pkg::node_type mem [cdll_pkg::NodeCount];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_idx] <= wr_node;
      rd_node <= mem[rd_idx];
   end
endmodule

>>> src/cdll_checker.sv
// Port checker for the cursor linked list, bound to the top level
`include "cursor_doubly_linked_list_macros.svh"
module cdll_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input cdll_pkg::rsp_type_type rsp_data
);
   `CDLL_ASSERT_IMP(a_one_at_a_time, clock, reset, rsp_valid, req_stall, "request taken while result pending")
   `CDLL_ASSERT_NXT(a_rsp_holds, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result changed")
   `CDLL_ASSERT_IMP(a_no_data_null, clock, reset, rsp_valid && !rsp_data.has_data, rsp_data.data_out == '0, "data without has_data")
   `CDLL_ASSERT_NXT(a_busy_after_req, clock, reset, req_valid && !req_stall, req_stall && !rsp_valid, "no work after transfer")
endmodule

bind cursor_doubly_linked_list cdll_checker u_cdll_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
);

>>> tb/cursor_doubly_linked_list_checker.sv
// Checker for the cursor linked list: tracks list state, predicts and compares results
module cursor_doubly_linked_list_checker
   import cdll_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   input  logic         req_stall,
   input  req_type_type req_data,
   input  logic         rsp_valid,
   input  logic         rsp_stall,
   input  rsp_type_type rsp_data,
   output int           fail_count,
   output int           pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   logic [DataWidth-1:0] pool_value [NodeCount];
   logic [PtrWidth-1:0]  pool_next [NodeCount];
   logic [PtrWidth-1:0]  pool_prev [NodeCount];
   logic [PtrWidth-1:0]  head, tail, cur;
   logic                 node_free [NodeCount];
   rsp_type_type         expected_rsps [$];

   function automatic logic is_node(logic [PtrWidth-1:0] p);
      return p < NullPtr;
   endfunction

   function automatic logic [PtrWidth-1:0] grab_node();
      for (int i = 0; i < NodeCount; i++) begin
         if (node_free[i]) begin
            node_free[i] = 1'b0;
            return PtrWidth'(i);
         end
      end
      return NullPtr;
   endfunction

   function automatic logic [1:0] link_after_cursor(logic [31:0] v);
      logic [PtrWidth-1:0] n, nx;
      if (!is_node(cur)) return StNullCursor;
      n = grab_node();
      if (!is_node(n)) return StFull;
      nx = pool_next[cur];
      pool_value[n] = v;
      pool_next[n] = nx;
      pool_prev[n] = cur;
      if (is_node(nx)) pool_prev[nx] = n;
      pool_next[cur] = n;
      if (tail == cur) tail = n;
      return StOk;
   endfunction

   function automatic logic [1:0] link_front(logic [31:0] v);
      logic [PtrWidth-1:0] n;
      n = grab_node();
      if (!is_node(n)) return StFull;
      pool_value[n] = v;
      pool_next[n] = head;
      pool_prev[n] = NullPtr;
      if (is_node(head)) pool_prev[head] = n;
      else tail = n;
      head = n;
      return StOk;
   endfunction

   function automatic logic [1:0] unlink_cursor(output logic [31:0] v, input logic [1:0] none);
      logic [PtrWidth-1:0] p, nx;
      v = '0;
      if (!is_node(cur)) return none;
      p = pool_prev[cur];
      nx = pool_next[cur];
      if (is_node(p)) pool_next[p] = nx;
      else head = nx;
      if (is_node(nx)) pool_prev[nx] = p;
      else tail = p;
      v = pool_value[cur];
      node_free[cur] = 1'b1;
      cur = nx;
      return StOk;
   endfunction

   function automatic rsp_type_type apply_request(req_type_type r);
      rsp_type_type res;
      logic [PtrWidth-1:0] t;
      logic [31:0] v;
      res = '0;
      case (r.req_type)
         OpFirst, OpLast: begin
            t = (r.req_type == OpFirst) ? head : tail;
            if (!is_node(t)) res.status = StEmpty;
            else begin
               cur = t;
               res.data_out = pool_value[t];
               res.has_data = 1'b1;
            end
         end
         OpNext, OpPrev: begin
            if (!is_node(cur)) res.status = StNullCursor;
            else begin
               t = (r.req_type == OpNext) ? pool_next[cur] : pool_prev[cur];
               if (!is_node(t)) res.status = StEmpty;
               else begin
                  cur = t;
                  res.data_out = pool_value[t];
                  res.has_data = 1'b1;
               end
            end
         end
         OpPushFront: res.status = link_front(r.data_in);
         OpPushBack: begin
            if (!is_node(tail)) res.status = link_front(r.data_in);
            else begin
               t = cur;
               cur = tail;
               res.status = link_after_cursor(r.data_in);
               if (res.status != StOk) cur = t;
            end
         end
         OpPushCursor: res.status = link_after_cursor(r.data_in);
         OpPopFront, OpPopBack, OpPopCursor: begin
            if (r.req_type == OpPopFront) cur = head;
            else if (r.req_type == OpPopBack) cur = tail;
            res.status = unlink_cursor(v, (r.req_type == OpPopCursor) ? StNullCursor : StEmpty);
            if (res.status == StOk) begin
               res.data_out = v;
               res.has_data = 1'b1;
            end
         end
         OpClear: begin
            for (int i = 0; i < NodeCount; i++) node_free[i] = 1'b1;
            head = NullPtr;
            tail = NullPtr;
            cur = NullPtr;
         end
         default: ;
      endcase
      return res;
   endfunction

   assign pending_count = expected_rsps.size();

   always @(posedge clock) begin
      rsp_type_type want;
      if (reset) begin
         head <= NullPtr;
         tail <= NullPtr;
         cur <= NullPtr;
         for (int i = 0; i < NodeCount; i++) node_free[i] = 1'b1;
         expected_rsps.delete();
         fail_count <= 0;
      end else begin
         if (req_valid && !req_stall) expected_rsps.push_back(apply_request(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               if (fail_count < 10) $display("unexpected result transfer: %p", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data.data_out !== want.data_out || rsp_data.has_data !== want.has_data
                     || rsp_data.status !== want.status) begin
                  if (fail_count < 10)
                     $display("mismatch: want data %h has %b st %0d, got data %h has %b st %0d",
                              want.data_out, want.has_data, want.status, rsp_data.data_out,
                              rsp_data.has_data, rsp_data.status);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end
endmodule

>>> tb/cursor_doubly_linked_list_tb.sv
// Testbench top: drives list requests with random idling and result stalls, and gives the verdict
module cursor_doubly_linked_list_tb;
   import cdll_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WatchdogLimit = 20000;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_type_type req_data = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_type_type rsp_data;
   int           fail_count;
   int           pending_count;
   int           send_idle_pct = 0;
   int           recv_stall_pct = 0;
   logic         hold_off = 1'b0;
   int           quiet_cycles = 0;

   cursor_doubly_linked_list uut (.*);
   cursor_doubly_linked_list_checker chk (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(negedge clock) begin
      if (reset || hold_off) rsp_stall <= 1'b1;
      else rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // one transfer on the request channel, with a random idle gap first;
   // valid stays high into the next call so items can follow back to back
   task automatic send_request(logic [3:0] op, logic [31:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{req_type: op, data_in: value};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      @(negedge clock);
   endtask

   function automatic logic [31:0] random_value();
      case ($urandom_range(3))
         0: return '0;
         1: return '1;
         default: return $urandom();
      endcase
   endfunction

   // pushes take push_bias percent of picks; the rest are moves, pops, clears and unused opcodes
   task automatic random_burst(int count, int push_bias);
      int pick;
      logic [3:0] op;
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(99);
         if (pick < push_bias) op = OpPushFront + 4'($urandom_range(2));
         else if (pick < 70) op = 4'($urandom_range(3));
         else if (pick < 95) op = OpPopFront + 4'($urandom_range(2));
         else if (pick < 97) op = OpClear;
         else op = 4'($urandom_range(11, 15));
         send_request(op, random_value());
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      // empty-list corners
      send_request(OpFirst, 0);
      send_request(OpLast, 0);
      send_request(OpNext, 0);
      send_request(OpPrev, 0);
      send_request(OpPushCursor, 32'h1);
      send_request(OpPopFront, 0);
      send_request(OpPopBack, 0);
      send_request(OpPopCursor, 0);
      send_request(OpPushBack, 32'hFFFF_FFFF);
      send_request(OpPushFront, 32'h0);
      send_request(OpPushBack, 32'hA5A5_5A5A);
      send_request(OpFirst, 0);
      send_request(OpPrev, 0);
      send_request(OpNext, 0);
      send_request(OpPushCursor, 32'h5A5A_A5A5);
      send_request(OpLast, 0);
      send_request(OpNext, 0);
      send_request(OpPopCursor, 0);
      send_request(OpPopBack, 0);
      send_request(4'd15, 32'hFFFF_FFFF);
      // fill the pool to the top and push past it
      for (int i = 0; i < NodeCount; i++) send_request(OpPushBack, $urandom());
      send_request(OpPushFront, 32'h1234_5678);
      send_request(OpPushCursor, 32'h1);
      send_request(OpClear, 0);

      random_burst(150, 45);
      send_idle_pct = 58;
      random_burst(120, 40);
      send_idle_pct = 0;
      recv_stall_pct = 58;
      random_burst(120, 40);
      send_idle_pct = 22;
      recv_stall_pct = 22;
      fork
         random_burst(120, 50);
         begin
            hold_off <= 1'b1;
            repeat (300) @(posedge clock);
            @(negedge clock);
            hold_off <= 1'b0;
         end
      join
      send_idle_pct = 0;
      recv_stall_pct = 0;
      random_burst(60, 30);
      req_valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end
endmodule
